>>> sv/zip_central_directory_parser_macros.svh
// ----------------------------------------------------------------------------
// zip_central_directory_parser assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ZIP_CENTRAL_DIRECTORY_PARSER_MACROS_SVH
`define ZIP_CENTRAL_DIRECTORY_PARSER_MACROS_SVH

// same-cycle implication
`define ZCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zcd assertion failed");

// next-cycle implication
`define ZCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zcd assertion failed");

`endif

>>> sv/zcd_pkg.sv
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared types and constants of the zip central directory parser.
// ----------------------------------------------------------------------------
package zcd_pkg;

	localparam logic [12:0] MAX_ENTRIES = 13'd4096;
	localparam logic [15:0] NAME_LIMIT  = 16'd511;
	localparam logic [5:0]  HDR_LAST    = 6'd45;
	localparam logic [7:0]  CHR_BSLASH  = 8'h5C;
	localparam logic [7:0]  CHR_SLASH   = 8'h2F;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  name_char;
		logic        has_name_char;
		logic        entry_done;
		logic        entry_kept;
		logic [31:0] lhdr_offset;
		logic [31:0] size_compressed;
		logic [31:0] size_uncompressed;
		logic [15:0] method;
		logic [15:0] name_length;
		logic [11:0] entry_index;
		logic        bad_signature;
		logic        directory_done;
	} zcd_result_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = 8'h50;
			2'd1: r = 8'h4B;
			2'd2: r = 8'h02;
			default: r = 8'h01;
		endcase
		return r;
	endfunction

endpackage

>>> sv/zcd_parser.sv
// ----------------------------------------------------------------------------
// zcd_parser
// Front end: takes one directory byte per transaction, tracks record
// position, gathers header fields and emits at most one result per byte.
// ----------------------------------------------------------------------------
`include "zip_central_directory_parser_macros.svh"

module zcd_parser import zcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [12:0]        cfg_count,
	input  logic               in_fire,
	input  logic [7:0]         data_byte,
	output logic               push,
	output zcd_result_t        res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_NAME   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [5:0]  hpos_q, hpos_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] csize_q, csize_d;
	logic [31:0] usize_q, usize_d;
	logic [15:0] method_q, method_d;
	logic [15:0] nm_size_q, nm_size_d;
	logic [15:0] xtra_size_q, xtra_size_d;
	logic [15:0] cmt_size_q, cmt_size_d;
	logic [16:0] bytes_left_q, bytes_left_d;
	logic [12:0] records_q, records_d;
	logic [12:0] kept_q, kept_d;
	logic [12:0] entry_count_q;

	logic        kept;
	logic        last_rec;
	logic [16:0] skip;
	logic        finish;
	logic [5:0]  p;
	logic [1:0]  off_lane;

	assign p        = hpos_q;
	assign off_lane = 2'(p[1:0] - 2'd2);
	assign kept     = (nm_size_q != 16'd0) && (nm_size_q < NAME_LIMIT)
	                  && (kept_q < MAX_ENTRIES);
	assign last_rec = (({1'b0, records_q} + 14'd1) >= {1'b0, entry_count_q});
	assign skip     = {1'b0, xtra_size_q} + {1'b0, cmt_size_q};

	always_comb begin
		phase_d      = phase_q;
		hpos_d       = hpos_q;
		offset_d     = offset_q;
		csize_d      = csize_q;
		usize_d      = usize_q;
		method_d     = method_q;
		nm_size_d    = nm_size_q;
		xtra_size_d  = xtra_size_q;
		cmt_size_d   = cmt_size_q;
		bytes_left_d = bytes_left_q;
		records_d    = records_q;
		kept_d       = kept_q;
		res          = '0;
		push         = 1'b0;
		finish       = 1'b0;

		if (in_fire) begin
			unique case (phase_q)
				PH_STOP: begin
				end
				PH_SKIP: begin
					if (bytes_left_q <= 17'd1) begin
						bytes_left_d = '0;
						phase_d      = PH_HEADER;
						hpos_d       = '0;
					end else begin
						bytes_left_d = bytes_left_q - 17'd1;
					end
				end
				PH_NAME: begin
					push              = 1'b1;
					res.name_char     = (data_byte == CHR_BSLASH) ? CHR_SLASH : data_byte;
					res.has_name_char = kept;
					if (bytes_left_q <= 17'd1) begin
						bytes_left_d = '0;
						finish       = 1'b1;
					end else begin
						bytes_left_d = bytes_left_q - 17'd1;
					end
				end
				default: begin
					if (p < 6'd4) begin
						if (data_byte != sig_byte(p[1:0])) begin
							push              = 1'b1;
							res.bad_signature = 1'b1;
							phase_d           = PH_STOP;
						end
					end else if (p == 6'd10 || p == 6'd11) begin
						method_d[{p[0], 3'b000} +: 8] = data_byte;
					end else if (p >= 6'd20 && p <= 6'd23) begin
						csize_d[{p[1:0], 3'b000} +: 8] = data_byte;
					end else if (p >= 6'd24 && p <= 6'd27) begin
						usize_d[{p[1:0], 3'b000} +: 8] = data_byte;
					end else if (p == 6'd28 || p == 6'd29) begin
						nm_size_d[{p[0], 3'b000} +: 8] = data_byte;
					end else if (p == 6'd30 || p == 6'd31) begin
						xtra_size_d[{p[0], 3'b000} +: 8] = data_byte;
					end else if (p == 6'd32 || p == 6'd33) begin
						cmt_size_d[{p[0], 3'b000} +: 8] = data_byte;
					end else if (p >= 6'd42 && p <= 6'd45) begin
						offset_d[{off_lane, 3'b000} +: 8] = data_byte;
					end

					if (!res.bad_signature) begin
						if (p >= HDR_LAST) begin
							hpos_d = '0;
							if (nm_size_q == 16'd0) begin
								push   = 1'b1;
								finish = 1'b1;
							end else begin
								bytes_left_d = {1'b0, nm_size_q};
								phase_d      = PH_NAME;
							end
						end else begin
							hpos_d = p + 6'd1;
						end
					end
				end
			endcase
		end

		if (finish) begin
			res.entry_done        = 1'b1;
			res.entry_kept        = kept;
			res.lhdr_offset       = offset_d;
			res.size_compressed   = csize_d;
			res.size_uncompressed = usize_d;
			res.method            = method_d;
			res.name_length       = nm_size_q;
			res.entry_index       = kept ? kept_q[11:0] : 12'd0;
			if (kept) begin
				kept_d = kept_q + 13'd1;
			end
			if (last_rec) begin
				res.directory_done = 1'b1;
				phase_d            = PH_STOP;
			end else begin
				records_d = records_q + 13'd1;
				hpos_d    = '0;
				if (skip == 17'd0) begin
					phase_d = PH_HEADER;
				end else begin
					bytes_left_d = skip;
					phase_d      = PH_SKIP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			hpos_q        <= '0;
			offset_q      <= '0;
			csize_q       <= '0;
			usize_q       <= '0;
			method_q      <= '0;
			nm_size_q     <= '0;
			xtra_size_q   <= '0;
			cmt_size_q    <= '0;
			bytes_left_q  <= '0;
			records_q     <= '0;
			kept_q        <= '0;
			entry_count_q <= 13'd1;
		end else begin
			phase_q       <= phase_d;
			hpos_q        <= hpos_d;
			offset_q      <= offset_d;
			csize_q       <= csize_d;
			usize_q       <= usize_d;
			method_q      <= method_d;
			nm_size_q     <= nm_size_d;
			xtra_size_q   <= xtra_size_d;
			cmt_size_q    <= cmt_size_d;
			bytes_left_q  <= bytes_left_d;
			records_q     <= records_d;
			kept_q        <= kept_d;
			if (cfg_we) begin
				entry_count_q <= cfg_count;
			end
		end
	end

	`ZCD_ASSERT_IMP(a_stop_silent, phase_q == PH_STOP, !push)
	`ZCD_ASSERT_NXT(a_bad_sig_stops, push && res.bad_signature, phase_q == PH_STOP)
	`ZCD_ASSERT_NXT(a_dir_done_stops, push && res.directory_done, phase_q == PH_STOP)
	`ZCD_ASSERT_IMP(a_kept_bound, 1'b1, kept_q <= MAX_ENTRIES)

endmodule

>>> sv/zcd_fifo.sv
// ----------------------------------------------------------------------------
// zcd_fifo
// Back end: short result queue feeding the output channel, so the parser
// and the consumer stall independently.
// ----------------------------------------------------------------------------
`include "zip_central_directory_parser_macros.svh"

module zcd_fifo import zcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  zcd_result_t push_data,
	output logic        full,
	output logic        out_valid,
	input  logic        out_ready,
	output zcd_result_t out_data
);

	zcd_result_t           mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
				            : wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
				            : rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	`ZCD_ASSERT_IMP(a_no_overflow, push, !full)
	`ZCD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`ZCD_ASSERT_NXT(a_push_visible, push && !pop, count_q != '0)

endmodule

>>> sv/zip_central_directory_parser.sv
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Each result is registered in the result queue and leaves it at the queue head.
// Throughput: one byte per cycle while in_ready is high; one parser state update per
// byte sets this. in_ready drops only while the four-entry result queue is full.
// Reset (arst_n low) clears all parser state and the queue; entry_count returns to 1.
// ----------------------------------------------------------------------------
module zip_central_directory_parser import zcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] entry_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  name_char,
	output logic        has_name_char,
	output logic        entry_done,
	output logic        entry_kept,
	output logic [31:0] lhdr_offset,
	output logic [31:0] size_compressed,
	output logic [31:0] size_uncompressed,
	output logic [15:0] method,
	output logic [15:0] name_length,
	output logic [11:0] entry_index,
	output logic        bad_signature,
	output logic        directory_done
);

	logic        in_fire;
	logic        push;
	logic        full;
	zcd_result_t res;
	zcd_result_t head;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign in_fire   = in_valid && in_ready;

	zcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_count (entry_count),
		.in_fire   (in_fire),
		.data_byte (data_byte),
		.push      (push),
		.res       (res)
	);

	zcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (head)
	);

	assign name_char         = head.name_char;
	assign has_name_char     = head.has_name_char;
	assign entry_done        = head.entry_done;
	assign entry_kept        = head.entry_kept;
	assign lhdr_offset       = head.lhdr_offset;
	assign size_compressed   = head.size_compressed;
	assign size_uncompressed = head.size_uncompressed;
	assign method            = head.method;
	assign name_length       = head.name_length;
	assign entry_index       = head.entry_index;
	assign bad_signature     = head.bad_signature;
	assign directory_done    = head.directory_done;

endmodule
